// File: hdl/hic_pkg.sv
package hic_pkg;

    localparam int AXES             = 3;
    localparam int DEF_SAMPLE_BITS  = 16;
    localparam int LIMIT_BITS       = 15;
    localparam int COUNT_BITS       = 8;
    localparam int OFFSET_BITS      = 16;
    localparam int CFG_INDEX_BITS   = 2;
    localparam int CFG_DATA_BITS    = 15;

    localparam logic [LIMIT_BITS-1:0] RST_OUTLIER_LIMIT = 15'd600;
    localparam logic [LIMIT_BITS-1:0] RST_REARM_BELOW   = 15'd40;
    localparam logic [LIMIT_BITS-1:0] RST_COUNT_ABOVE   = 15'd200;
    localparam logic [COUNT_BITS-1:0] RST_NEEDED_SWINGS = 8'd5;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX         = 8'd255;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_OUTLIER_LIMIT = 2'd0,
        CFG_REARM_BELOW   = 2'd1,
        CFG_COUNT_ABOVE   = 2'd2,
        CFG_NEEDED_SWINGS = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [LIMIT_BITS-1:0] outlier_limit;
        logic [LIMIT_BITS-1:0] rearm_below;
        logic [LIMIT_BITS-1:0] count_above;
        logic [COUNT_BITS-1:0] needed_swings;
    } t_cfg;

    typedef struct packed {
        logic over_limit;
        logic met_now;
        logic met_next;
    } t_lane_status;

endpackage

// File: hdl/hard_iron_offset_calibrator.sv
// Hard-iron offset calibrator, min/max method, three axes.
// Input channel: i_valid / o_stall with i_sample_x/y/z. A transaction is taken
// at a clock edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall with o_accepted, o_finished and the three
// offsets (max plus min per axis, saturated to +/-32767).
// Config channel: i_cfg_valid / o_cfg_ready (always high), i_cfg_index selects
// outlier_limit, rearm_below, count_above, needed_swings. Write only while idle.
// Each axis has its own lane; a merge stage combines outlier and swing status.
// A result is registered and valid in the cycle after its input. Throughput: one
// sample per cycle unless the receiver stalls, set by each lane's compare/update.
// When the receiver stalls, the result holds and o_stall rises only while a
// result is pending; the next sample is taken in the cycle the result leaves.
// Reset (i_rst_n low, synchronous) clears min/max, arming, counts, the done
// flag and the output valid, and loads the default thresholds. After finishing
// the block freezes and reports finished with held offsets until reset.
module hard_iron_offset_calibrator
    import hic_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_x,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_y,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_z,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_accepted,
    output logic                          o_finished,
    output logic signed [OFFSET_BITS-1:0] o_offset_x_times2,
    output logic signed [OFFSET_BITS-1:0] o_offset_y_times2,
    output logic signed [OFFSET_BITS-1:0] o_offset_z_times2,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0]     i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]      i_cfg_data
);

    t_cfg         r_cfg;
    logic         r_out_valid;
    logic         r_accepted;
    logic         r_done;

    logic signed [SAMPLE_BITS-1:0] sample [AXES];
    logic signed [OFFSET_BITS-1:0] offset [AXES];
    t_lane_status                  status [AXES];

    logic take;
    logic update;
    logic accepted;
    logic n_done;

    assign sample[0] = i_sample_x;
    assign sample[1] = i_sample_y;
    assign sample[2] = i_sample_z;

    assign o_stall     = r_out_valid && i_stall;
    assign take        = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    for (genvar a = 0; a < AXES; a++) begin : g_lane
        hic_lane #(
            .SAMPLE_BITS(SAMPLE_BITS)
        ) u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_sample (sample[a]),
            .i_en     (update),
            .i_cfg    (r_cfg),
            .o_status (status[a]),
            .o_offset (offset[a])
        );
    end

    hic_merge u_merge (
        .i_status   (status),
        .i_done     (r_done),
        .i_take     (take),
        .o_update   (update),
        .o_accepted (accepted),
        .o_done     (n_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.outlier_limit <= RST_OUTLIER_LIMIT;
            r_cfg.rearm_below   <= RST_REARM_BELOW;
            r_cfg.count_above   <= RST_COUNT_ABOVE;
            r_cfg.needed_swings <= RST_NEEDED_SWINGS;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_OUTLIER_LIMIT: r_cfg.outlier_limit <= i_cfg_data[LIMIT_BITS-1:0];
                CFG_REARM_BELOW:   r_cfg.rearm_below   <= i_cfg_data[LIMIT_BITS-1:0];
                CFG_COUNT_ABOVE:   r_cfg.count_above   <= i_cfg_data[LIMIT_BITS-1:0];
                CFG_NEEDED_SWINGS: r_cfg.needed_swings <= i_cfg_data[COUNT_BITS-1:0];
                default:           r_cfg               <= r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_accepted  <= 1'b0;
            r_done      <= 1'b0;
        end else begin
            if (take) begin
                r_out_valid <= 1'b1;
                r_accepted  <= accepted;
                r_done      <= n_done;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid           = r_out_valid;
    assign o_accepted        = r_accepted;
    assign o_finished        = r_done;
    assign o_offset_x_times2 = offset[0];
    assign o_offset_y_times2 = offset[1];
    assign o_offset_z_times2 = offset[2];

endmodule

// File: hdl/hic_lane.sv
module hic_lane
    import hic_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_en,
    input  t_cfg                          i_cfg,
    output t_lane_status                  o_status,
    output logic signed [OFFSET_BITS-1:0] o_offset
);

    localparam int CW = (SAMPLE_BITS > LIMIT_BITS) ? SAMPLE_BITS : LIMIT_BITS;
    localparam int SW = (SAMPLE_BITS + 1 > OFFSET_BITS + 1) ? SAMPLE_BITS + 1 : OFFSET_BITS + 1;
    localparam logic signed [SW-1:0] SAT_HI = SW'(32767);
    localparam logic signed [SW-1:0] SAT_LO = -SW'(32767);

    logic signed [SAMPLE_BITS-1:0] r_min, n_min;
    logic signed [SAMPLE_BITS-1:0] r_max, n_max;
    logic                          r_armed, n_armed;
    logic [COUNT_BITS-1:0]         r_count, n_count;

    logic [SAMPLE_BITS-1:0] mag;
    logic [CW-1:0]          mag_c;
    logic signed [SW-1:0]   sum;

    assign mag   = i_sample[SAMPLE_BITS-1] ? (~i_sample + 1'b1) : i_sample;
    assign mag_c = CW'(mag);

    always_comb begin
        n_min   = r_min;
        n_max   = r_max;
        n_armed = r_armed;
        n_count = r_count;
        if (r_min > i_sample) begin
            n_min = i_sample;
        end else if (r_max < i_sample) begin
            n_max = i_sample;
        end
        if (r_armed) begin
            if (mag_c > CW'(i_cfg.count_above)) begin
                n_armed = 1'b0;
                if (r_count != COUNT_MAX) begin
                    n_count = r_count + 1'b1;
                end
            end
        end else begin
            n_armed = mag_c < CW'(i_cfg.rearm_below);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min   <= '0;
            r_max   <= '0;
            r_armed <= 1'b0;
            r_count <= '0;
        end else if (i_en) begin
            r_min   <= n_min;
            r_max   <= n_max;
            r_armed <= n_armed;
            r_count <= n_count;
        end
    end

    assign o_status.over_limit = mag_c > CW'(i_cfg.outlier_limit);
    assign o_status.met_now    = r_count >= i_cfg.needed_swings;
    assign o_status.met_next   = n_count >= i_cfg.needed_swings;

    always_comb begin
        sum = SW'(r_max) + SW'(r_min);
        if (sum > SAT_HI) begin
            o_offset = OFFSET_BITS'(SAT_HI);
        end else if (sum < SAT_LO) begin
            o_offset = OFFSET_BITS'(SAT_LO);
        end else begin
            o_offset = sum[OFFSET_BITS-1:0];
        end
    end

endmodule

// File: hdl/hic_merge.sv
module hic_merge
    import hic_pkg::*;
(
    input  t_lane_status i_status [AXES],
    input  logic         i_done,
    input  logic         i_take,
    output logic         o_update,
    output logic         o_accepted,
    output logic         o_done
);

    logic any_over;
    logic all_now;
    logic all_next;
    logic done_start;

    always_comb begin
        any_over = 1'b0;
        all_now  = 1'b1;
        all_next = 1'b1;
        for (int a = 0; a < AXES; a++) begin
            any_over = any_over | i_status[a].over_limit;
            all_now  = all_now  & i_status[a].met_now;
            all_next = all_next & i_status[a].met_next;
        end
        done_start = i_done | all_now;
        o_accepted = !done_start && !any_over;
        o_update   = i_take && o_accepted;
        o_done     = done_start | (o_accepted & all_next);
    end

endmodule
